FILE: rtl/bptk_pkg.sv
// Shared types and constants for the top-k priority collector.
package bptk_pkg;

  localparam int CAPACITY_DEF     = 32;
  localparam int ZONE_ID_BITS_DEF = 12;

  localparam int ZONE_W   = 12;
  localparam int PRIO_W   = 32;
  localparam int RANK_W   = 5;
  localparam int BUDGET_W = 6;
  localparam int OP_W     = 2;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 6'd8;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ZONE_W-1:0] zone_id;
    logic              force_req;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [ZONE_W-1:0] out_zone_id;
    logic              out_force;
    logic [PRIO_W-1:0] out_priority;
    logic [RANK_W-1:0] rank;
    logic              empty_res;
    logic              overflowed;
    logic              last;
  } out_item_t;

  typedef logic [BUDGET_W-1:0] cfg_item_t;

  // Per-cycle command shared by every cell of the chain.
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

endpackage

FILE: rtl/bptk_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface bptk_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bptk_cell.sv
// One slot of the sorted list: compare against the candidate, insert, shift or rotate.
module bptk_cell #(
  parameter int ZONE_ID_BITS = bptk_pkg::ZONE_ID_BITS_DEF
) (
  input  logic                     clk,
  input  bptk_pkg::cell_ctl_t      ctl,
  input  logic                     occupied,
  input  logic [ZONE_ID_BITS-1:0]  new_zone,
  input  logic                     new_force,
  input  logic [bptk_pkg::PRIO_W-1:0] new_prio,
  input  logic                     prev_m,
  input  logic [ZONE_ID_BITS-1:0]  prev_zone,
  input  logic                     prev_force,
  input  logic [bptk_pkg::PRIO_W-1:0] prev_prio,
  input  logic [ZONE_ID_BITS-1:0]  rot_zone,
  input  logic                     rot_force,
  input  logic [bptk_pkg::PRIO_W-1:0] rot_prio,
  output logic [ZONE_ID_BITS-1:0]  zone,
  output logic                     force_o,
  output logic [bptk_pkg::PRIO_W-1:0] prio,
  output logic                     m
);
  import bptk_pkg::*;

  logic [ZONE_ID_BITS-1:0] zone_r;
  logic                    force_r;
  logic [PRIO_W-1:0]       prio_r;

  // Free slot or a held key not above the candidate: candidate belongs here or earlier.
  assign m = !occupied || ({force_r, prio_r} <= {new_force, new_prio});

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      zone_r  <= rot_zone;
      force_r <= rot_force;
      prio_r  <= rot_prio;
    end else if (ctl.insert) begin
      if (prev_m) begin
        zone_r  <= prev_zone;
        force_r <= prev_force;
        prio_r  <= prev_prio;
      end else if (m) begin
        zone_r  <= new_zone;
        force_r <= new_force;
        prio_r  <= new_prio;
      end
    end
  end

  assign zone    = zone_r;
  assign force_o = force_r;
  assign prio    = prio_r;

endmodule

FILE: rtl/bounded_priority_topk_collector.sv
// Top level: sorted top-k candidate list built from a chain of compare-and-shift cells.
// Clear empties the list and its overflow flag. Offer: insert in the cell chain, then a
// tail trim against budget in S_TRIM. Dump: one result per cycle once the output register
// is free; after the transfer the state moves to S_DUMP, which fills the output register
// with each result in turn; an empty list gives a single result flagged empty and last.
// One item is in work at a time; cfg writes are taken every cycle (ready tied high).
// Reset clears state, entry count, overflow flag, output valid; budget returns to 8.
// Cell contents are not reset and are read only below the entry count.
module bounded_priority_topk_collector #(
  parameter int CAPACITY     = bptk_pkg::CAPACITY_DEF,
  parameter int ZONE_ID_BITS = bptk_pkg::ZONE_ID_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  bptk_stream_if.sink   in_if,
  bptk_stream_if.source out_if,
  bptk_stream_if.sink   cfg_if
);
  import bptk_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > BUDGET_W) ? CNT_W : BUDGET_W;

  typedef enum logic [1:0] {S_IDLE, S_TRIM, S_DUMP} state_t;

  state_t              state_r,     state_nxt;
  logic [CNT_W-1:0]    count_r,     count_nxt;
  logic [CNT_W-1:0]    dump_idx_r,  dump_idx_nxt;
  logic                ovf_r,       ovf_nxt;
  logic [BUDGET_W-1:0] budget_r,    budget_nxt;
  out_item_t           out_r,       out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Chain taps
  logic [ZONE_ID_BITS-1:0] zone_v  [CAPACITY];
  logic                    force_v [CAPACITY];
  logic [PRIO_W-1:0]       prio_v  [CAPACITY];
  logic [CAPACITY-1:0]     m_v;
  logic [CAPACITY-1:0]     occ_v;
  logic [CAPACITY-1:0]     wrap_v;

  cell_ctl_t               ctl;
  in_item_t                in_d;
  logic [ZONE_ID_BITS-1:0] new_zone;
  logic                    in_xfer;
  logic                    any_le;
  logic                    full;
  logic                    insert_go;
  logic                    out_free;
  logic                    tail_force;
  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        budget_ext;
  logic [CNT_W-1:0]        count_m1;

  assign in_d      = in_if.data;
  assign new_zone  = ZONE_ID_BITS'(in_d.zone_id);
  assign in_xfer   = in_if.valid && in_if.ready;
  assign count_ext = CMP_W'(count_r);
  assign budget_ext = CMP_W'(budget_r);
  assign count_m1  = count_r - CNT_W'(1);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign out_free  = !out_valid_r || out_if.ready;

  // Some held entry sorts at or below the candidate.
  assign any_le    = |(m_v & occ_v);
  assign insert_go = in_xfer && (in_d.opcode == OP_OFFER) &&
                     (in_d.force_req || any_le || (count_ext < budget_ext));

  assign tail_force = force_v[count_m1[IDX_W-1:0]];

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Build the chain: each cell sees its upstream neighbor for insert shifts and
  // its downstream neighbor (or the head, at the tail of the list) for dump rotation.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_m;
    logic [ZONE_ID_BITS-1:0] prev_zone, rot_zone;
    logic                    prev_force, rot_force;
    logic [PRIO_W-1:0]       prev_prio, rot_prio;

    assign occ_v[i]  = (CNT_W'(i) < count_r);
    assign wrap_v[i] = (CNT_W'(i) == count_m1);

    if (i == 0) begin : g_head
      assign prev_m     = 1'b0;
      assign prev_zone  = new_zone;
      assign prev_force = in_d.force_req;
      assign prev_prio  = in_d.priority_req;
    end else begin : g_body
      assign prev_m     = m_v[i-1];
      assign prev_zone  = zone_v[i-1];
      assign prev_force = force_v[i-1];
      assign prev_prio  = prio_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rot_zone  = zone_v[0];
      assign rot_force = force_v[0];
      assign rot_prio  = prio_v[0];
    end else begin : g_link
      assign rot_zone  = wrap_v[i] ? zone_v[0]  : zone_v[i+1];
      assign rot_force = wrap_v[i] ? force_v[0] : force_v[i+1];
      assign rot_prio  = wrap_v[i] ? prio_v[0]  : prio_v[i+1];
    end

    bptk_cell #(
      .ZONE_ID_BITS(ZONE_ID_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ_v[i]),
      .new_zone  (new_zone),
      .new_force (in_d.force_req),
      .new_prio  (in_d.priority_req),
      .prev_m    (prev_m),
      .prev_zone (prev_zone),
      .prev_force(prev_force),
      .prev_prio (prev_prio),
      .rot_zone  (rot_zone),
      .rot_force (rot_force),
      .rot_prio  (rot_prio),
      .zone      (zone_v[i]),
      .force_o   (force_v[i]),
      .prio      (prio_v[i]),
      .m         (m_v[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    ovf_nxt       = ovf_r;
    budget_nxt    = budget_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    ctl           = '0;

    if (cfg_if.valid && cfg_if.ready) begin
      budget_nxt = cfg_if.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_d.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            OP_OFFER: begin
              ctl.insert = insert_go;
              if (insert_go) begin
                // A full list drops whatever falls past the end and stays full.
                if (full) begin
                  ovf_nxt = 1'b1;
                end else begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              state_nxt = S_TRIM;
            end
            OP_DUMP: begin
              dump_idx_nxt = '0;
              state_nxt    = S_DUMP;
            end
            default: ;
          endcase
        end
      end
      S_TRIM: begin
        // Drop one non-forced tail entry if the list is over budget.
        if ((count_ext > budget_ext) && (count_r != '0) && !tail_force) begin
          count_nxt = count_m1;
        end
        state_nxt = S_IDLE;
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_nxt            = '0;
            out_nxt.empty_res  = 1'b1;
            out_nxt.overflowed = ovf_r;
            out_nxt.last       = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            // Emit the head and rotate it to the tail of the occupied run.
            out_nxt.out_zone_id  = ZONE_W'(zone_v[0]);
            out_nxt.out_force    = force_v[0];
            out_nxt.out_priority = prio_v[0];
            out_nxt.rank         = RANK_W'(dump_idx_r);
            out_nxt.empty_res    = 1'b0;
            out_nxt.overflowed   = ovf_r;
            out_nxt.last         = (dump_idx_r == count_m1);
            ctl.rotate           = 1'b1;
            dump_idx_nxt         = dump_idx_r + CNT_W'(1);
            if (dump_idx_r == count_m1) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      ovf_r       <= 1'b0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      ovf_r       <= ovf_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

FILE: rtl/bptk_checker.sv
// Port-level checks for the top-k collector, bound to the top level.
module bptk_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [bptk_pkg::OP_W-1:0]   in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_last,
  input logic                        out_empty,
  input logic                        out_force,
  input logic [bptk_pkg::RANK_W-1:0] out_rank
);
  import bptk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && (out_rank == '0) && !out_force)
    else $error("empty dump result malformed");

  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_opcode == OP_OFFER) || (in_opcode == OP_DUMP))
      |=> !in_ready)
    else $error("new item taken while offer or dump in work");

  a_dump_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("input opened before dump ended");

endmodule

bind bounded_priority_topk_collector bptk_checker u_bptk_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .in_opcode(in_if.data.opcode),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_last (out_if.data.last),
  .out_empty(out_if.data.empty_res),
  .out_force(out_if.data.out_force),
  .out_rank (out_if.data.rank)
);

FILE: tb/tb_bounded_priority_topk_collector.sv
// Self-checking testbench for the top-k priority collector: directed table, then random phases.
module tb_bounded_priority_topk_collector;
  import bptk_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;

  // Opcode 3 has no meaning; the block must drop it without a result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Offer goes through insert and a tail trim in the block; give it a margin before a budget write.
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 240;
  localparam int BUSY_IDLE_PCT = 38;
  localparam int MAX_REPORTS   = 30;

  // One row of the directed table: either a budget write or one item, with the
  // dump result typed in where it is obvious.
  typedef struct packed {
    bit                  cfg_write;
    logic [BUDGET_W-1:0] budget;
    in_item_t            item;
    bit                  typed;
    out_item_t           want;
  } plan_row_t;

  // Entry of the predicted sorted list.
  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic              forced;
    logic [PRIO_W-1:0] prio;
  } cand_t;

  localparam out_item_t EMPTY_DUMP = '{out_zone_id: '0, out_force: 1'b0, out_priority: '0,
                                       rank: '0, empty_res: 1'b1, overflowed: 1'b0,
                                       last: 1'b1};
  localparam out_item_t TOP_ENTRY  = '{out_zone_id: 12'hfff, out_force: 1'b1,
                                       out_priority: 32'hffff_ffff, rank: '0,
                                       empty_res: 1'b0, overflowed: 1'b0, last: 1'b1};
  localparam out_item_t NO_WANT    = '0;

  localparam int PLAN_LEN = 27;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    // Empty list right after reset, then the largest possible key alone.
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b1, EMPTY_DUMP},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'hfff, 1'b1, 32'hffff_ffff}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b1, TOP_ENTRY},
    // Smallest key, equal keys (newer one goes first), forced with zero priority.
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h555, 1'b0, 32'h0001_8000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'haaa, 1'b0, 32'h0001_8000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h123, 1'b1, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_UNUSED, 12'h800, 1'b1, 32'h8000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b1, EMPTY_DUMP},
    // Zero budget: only forced candidates stay.
    '{1'b1, 6'd0,  '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h0f0, 1'b0, 32'hffff_ffff}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h00f, 1'b1, 32'h0000_0010}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    // Fill past a lowered budget; a rejected offer must still trim the tail.
    '{1'b1, 6'd8,  '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h321, 1'b0, 32'h0001_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h654, 1'b0, 32'h0002_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h987, 1'b0, 32'h0003_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'hcba, 1'b0, 32'h0004_0000}, 1'b0, NO_WANT},
    '{1'b1, 6'd2,  '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h111, 1'b0, 32'h0000_0001}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    // Budget above capacity.
    '{1'b1, 6'd63, '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_OFFER,  12'h7ff, 1'b0, 32'h7fff_ffff}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_DUMP,   12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT},
    '{1'b0, 6'd0,  '{OP_CLEAR,  12'h000, 1'b0, 32'h0000_0000}, 1'b0, NO_WANT}
  };

  localparam logic [BUDGET_W-1:0] BUDGET_PICKS [8] = '{6'd0, 6'd1, 6'd2, 6'd8,
                                                       6'd31, 6'd32, 6'd33, 6'd63};

  logic clk = 1'b0;
  logic rst_n;

  bptk_stream_if #(.T(in_item_t))  in_ch ();
  bptk_stream_if #(.T(out_item_t)) out_ch ();
  bptk_stream_if #(.T(cfg_item_t)) cfg_ch ();

  bounded_priority_topk_collector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predicted list state and the budget the block currently holds.
  cand_t               ranked [CAPACITY];
  int                  held;
  bit                  overflow_seen;
  logic [BUDGET_W-1:0] budget_now;

  out_item_t step_results [$];   // results caused by the latest transfer
  out_item_t dump_queue [$];     // dump results still awaited, oldest first

  int          idle_pct = BUSY_IDLE_PCT;
  int unsigned cycle_count = 0;
  int          error_count;
  int          items_sent;
  int          random_items;
  int          results_checked;
  int          overflow_results;
  int          phase_count;
  out_item_t   seen_result;
  out_item_t   awaited_result;

  // Clock: 10 time units per period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d results still awaited", cycle_count,
             dump_queue.size());
    $display("tb: failure");
    $finish;
  end

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("tb: mismatch in %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  // Insert one candidate into the predicted list, then trim against the budget.
  function automatic void offer_candidate(input cand_t c);
    int pos;
    pos = held;
    // Walk from the tail so the first entry with a key not above ours wins.
    for (int i = held - 1; i >= 0; i--)
      if ({ranked[i].forced, ranked[i].prio} <= {c.forced, c.prio}) pos = i;
    if (c.forced || pos < held || held < int'(budget_now)) begin
      if (held >= CAPACITY) begin
        // Full: drop whatever falls off the end, the candidate itself included.
        overflow_seen = 1'b1;
        if (pos < CAPACITY) begin
          for (int i = CAPACITY - 1; i > pos; i--) ranked[i] = ranked[i - 1];
          ranked[pos] = c;
        end
      end else begin
        for (int i = held; i > pos; i--) ranked[i] = ranked[i - 1];
        ranked[pos] = c;
        held++;
      end
    end
    if (held > int'(budget_now) && held > 0 && !ranked[held - 1].forced) held--;
  endfunction

  // Advance the predicted state by one transfer and collect its results.
  function automatic void apply_item(input in_item_t it);
    out_item_t r;
    cand_t     c;
    step_results.delete();
    case (it.opcode)
      OP_CLEAR: begin
        held = 0;
        overflow_seen = 1'b0;
      end
      OP_OFFER: begin
        c.zone   = it.zone_id;
        c.forced = it.force_req;
        c.prio   = it.priority_req;
        offer_candidate(c);
      end
      OP_DUMP: begin
        if (held == 0) begin
          r = EMPTY_DUMP;
          r.overflowed = overflow_seen;
          step_results.push_back(r);
        end else begin
          for (int i = 0; i < held; i++) begin
            r.out_zone_id  = ranked[i].zone;
            r.out_force    = ranked[i].forced;
            r.out_priority = ranked[i].prio;
            r.rank         = RANK_W'(i);
            r.empty_res    = 1'b0;
            r.overflowed   = overflow_seen;
            r.last         = (i == held - 1);
            step_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then record
  // what it should produce.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
    apply_item(it);
    if (typed) dump_queue.push_back(want);
    else foreach (step_results[i]) dump_queue.push_back(step_results[i]);
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (dump_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    budget_now = value;
  endtask

  // Result side: stall at random, except in the calm stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result = out_ch.data;
      if (dump_queue.size() == 0) begin
        note_mismatch("unexpected result, zone", seen_result.out_zone_id, 0);
      end else begin
        awaited_result = dump_queue.pop_front();
        results_checked++;
        if (seen_result.overflowed) overflow_results++;
        if (seen_result.out_zone_id !== awaited_result.out_zone_id)
          note_mismatch("out_zone_id", seen_result.out_zone_id, awaited_result.out_zone_id);
        if (seen_result.out_force !== awaited_result.out_force)
          note_mismatch("out_force", seen_result.out_force, awaited_result.out_force);
        if (seen_result.out_priority !== awaited_result.out_priority)
          note_mismatch("out_priority", seen_result.out_priority,
                        awaited_result.out_priority);
        if (seen_result.rank !== awaited_result.rank)
          note_mismatch("rank", seen_result.rank, awaited_result.rank);
        if (seen_result.empty_res !== awaited_result.empty_res)
          note_mismatch("empty_res", seen_result.empty_res, awaited_result.empty_res);
        if (seen_result.overflowed !== awaited_result.overflowed)
          note_mismatch("overflowed", seen_result.overflowed, awaited_result.overflowed);
        if (seen_result.last !== awaited_result.last)
          note_mismatch("last", seen_result.last, awaited_result.last);
      end
    end
  end

  initial begin
    in_item_t            it;
    logic [BUDGET_W-1:0] phase_budget;
    int                  phase_len;
    int                  dump_pct;
    int                  force_pct;
    int                  prio_style;
    int                  pick;

    // Hold every input at a known value, then apply reset.
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    held          = 0;
    overflow_seen = 1'b0;
    budget_now    = BUDGET_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].cfg_write) begin
        settle();
        write_budget(DIRECTED_PLAN[i].budget);
      end else begin
        push_item(DIRECTED_PLAN[i].item, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end
    end

    // Random phases: a budget per phase, then offer-heavy sequences closed by a dump.
    while (random_items < RANDOM_ITEMS) begin
      settle();
      phase_count++;
      // Run two phases with both sides fully busy.
      idle_pct = (phase_count == 3 || phase_count == 4) ? 0 : BUSY_IDLE_PCT;
      pick = $urandom_range(0, 8);
      phase_budget = (pick == 8) ? BUDGET_PICKS[$urandom_range(0, 7)] :
                     BUDGET_PICKS[pick];
      if (pick == 8 && $urandom_range(1)) phase_budget = BUDGET_W'($urandom_range(0, 63));
      write_budget(phase_budget);
      // Large budgets need long runs of offers to reach the capacity limit.
      phase_len  = (phase_budget >= 6'd32) ? $urandom_range(40, 65) : $urandom_range(8, 35);
      dump_pct   = (phase_budget >= 6'd32) ? 3 : 12;
      force_pct  = $urandom_range(0, 40);
      prio_style = $urandom_range(0, 2);
      for (int n = 0; n < phase_len; n++) begin
        pick = $urandom_range(99);
        it.zone_id   = ZONE_W'($urandom_range(0, 4095));
        it.force_req = ($urandom_range(99) < force_pct);
        case (prio_style)
          0: it.priority_req = $urandom;
          1: begin
            // Few distinct values: plenty of equal keys.
            case ($urandom_range(0, 4))
              0: it.priority_req = 32'h0000_0000;
              1: it.priority_req = 32'h0000_0001;
              2: it.priority_req = 32'h0000_8000;
              3: it.priority_req = 32'h0001_0000;
              default: it.priority_req = 32'hffff_ffff;
            endcase
          end
          default: it.priority_req = {16'($urandom_range(0, 15)), 16'h0000};
        endcase
        if (n == phase_len - 1) it.opcode = OP_DUMP;
        else if (pick < 3) it.opcode = OP_UNUSED;
        else if (pick < 7) it.opcode = OP_CLEAR;
        else if (pick < 7 + dump_pct) it.opcode = OP_DUMP;
        else it.opcode = OP_OFFER;
        if (it.opcode != OP_UNUSED) random_items++;
        push_item(it, 1'b0, NO_WANT);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (dump_queue.size() != 0)
      note_mismatch("results never seen, count", dump_queue.size(), 0);

    $display("tb: %0d transfers in, %0d results checked over %0d random phases",
             items_sent, results_checked, phase_count);
    $display("tb: %0d results carried the overflow flag, %0d mismatches",
             overflow_results, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
